// ===== rtl/core/rpwd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpwd_pkg
// Shared widths, register indexes and frame layout constants of the
// pulse-width remote decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rpwd_pkg;

  // item field widths
  localparam int unsigned DurW    = 24;
  localparam int unsigned SerialW = 28;
  localparam int unsigned CryptW  = 32;
  localparam int unsigned ButtonW = 4;

  // configuration port widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // register widths
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned CodeW  = 7;

  // frame layout
  localparam int unsigned MaxCodeBits = 66;
  localparam int unsigned LongFrame   = 66;
  localparam int unsigned ShortFrame  = 12;
  localparam int unsigned LongSerLsb  = 32;
  localparam int unsigned ShortSerW   = 12;

  // register reset values
  localparam logic [TimeW-1:0]  UnitTimeRst  = 16'd320;
  localparam logic [TimeW-1:0]  TolRst       = 16'd100;
  localparam logic [DurW-1:0]   MaxPauseRst  = 24'd20000;
  localparam logic [CountW-1:0] PreambleRst  = 8'd0;
  localparam logic [CountW-1:0] HeaderRst    = 8'd36;
  localparam logic [CountW-1:0] TailRst      = 8'd0;
  localparam logic [CodeW-1:0]  CodeLenRst   = 7'd12;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgUnitTime    = 3'd0,
    CfgTolerance   = 3'd1,
    CfgMaxPause    = 3'd2,
    CfgPreamble    = 3'd3,
    CfgHeader      = 3'd4,
    CfgTail        = 3'd5,
    CfgCodeLength  = 3'd6,
    CfgInvertLevel = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== rtl/core/remote_pulse_width_decoder_top.sv =====
// ----------------------------------------------------------------------------
// remote_pulse_width_decoder_top
// Pulse-width remote control decoder: preamble count, header check, data
// bits from pulse widths, optional tail, frame split into result fields.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   pulse_duration_i, line_level_i
//  out      output     out_valid_o / out_stall_i serial_number_o, encrypted_word_o,
//                                                button_bits_o, battery_low_o,
//                                                repeat_flag_o
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  an item is registered at accept and, unless the output register is full and
//  stalled, decoded in the next cycle, so its result is offered right after the
//  following edge; one item per cycle is sustained while the output is not stalled
//  decoding of the held item waits only while the output register is full
//  and stalled; in_stall_o rises only then
//  header and tail window centers are products kept in registers, refreshed
//  by the configuration write itself
//  rst_ni clears the control and decode state but the bit store, and loads register defaults
//
`default_nettype none

module remote_pulse_width_decoder_top
  import rpwd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input items
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [DurW-1:0]      pulse_duration_i,
  input  wire logic                 line_level_i,
  // result items
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [SerialW-1:0]        serial_number_o,
  output logic [CryptW-1:0]         encrypted_word_o,
  output logic [ButtonW-1:0]        button_bits_o,
  output logic                      battery_low_o,
  output logic                      repeat_flag_o,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned WinW  = DurW + 1;
  localparam int unsigned Tol4W = TimeW + 2;
  localparam int unsigned BitIdxW = $clog2(MaxCodeBits + 1);

  function automatic logic [DurW-1:0] mul_te(input logic [TimeW-1:0] te,
                                             input logic [CountW-1:0] n);
    mul_te = DurW'(te) * DurW'(n);
  endfunction

  // d lies strictly inside (c - t, c + t), without a signed lower bound
  function automatic logic in_win(input logic [DurW-1:0] d,
                                  input logic [DurW-1:0] c,
                                  input logic [Tol4W-1:0] t);
    in_win = ((WinW'(d) + WinW'(t)) > WinW'(c)) && (WinW'(d) < (WinW'(c) + WinW'(t)));
  endfunction

  // configuration registers
  logic [TimeW-1:0]  unit_time_q;
  logic [TimeW-1:0]  tol_q;
  logic [DurW-1:0]   max_pause_q;
  logic [CountW-1:0] preamble_len_q;
  logic [CountW-1:0] header_len_q;
  logic [CountW-1:0] tail_len_q;
  logic [CodeW-1:0]  code_len_q;
  logic              invert_q;
  logic [DurW-1:0]   hdr_c_q;
  logic [DurW-1:0]   tail_c_q;

  assign cfg_ready_o = 1'b1;

  // register writes, window centers follow the new value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_time_q    <= UnitTimeRst;
      tol_q          <= TolRst;
      max_pause_q    <= MaxPauseRst;
      preamble_len_q <= PreambleRst;
      header_len_q   <= HeaderRst;
      tail_len_q     <= TailRst;
      code_len_q     <= CodeLenRst;
      invert_q       <= 1'b0;
      hdr_c_q        <= mul_te(UnitTimeRst, HeaderRst);
      tail_c_q       <= mul_te(UnitTimeRst, TailRst);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgUnitTime: begin
          unit_time_q <= cfg_data_i[TimeW-1:0];
          hdr_c_q     <= mul_te(cfg_data_i[TimeW-1:0], header_len_q);
          tail_c_q    <= mul_te(cfg_data_i[TimeW-1:0], tail_len_q);
        end
        CfgTolerance:   tol_q          <= cfg_data_i[TimeW-1:0];
        CfgMaxPause:    max_pause_q    <= cfg_data_i[DurW-1:0];
        CfgPreamble:    preamble_len_q <= cfg_data_i[CountW-1:0];
        CfgHeader: begin
          header_len_q <= cfg_data_i[CountW-1:0];
          hdr_c_q      <= mul_te(unit_time_q, cfg_data_i[CountW-1:0]);
        end
        CfgTail: begin
          tail_len_q <= cfg_data_i[CountW-1:0];
          tail_c_q   <= mul_te(unit_time_q, cfg_data_i[CountW-1:0]);
        end
        CfgCodeLength:  code_len_q     <= cfg_data_i[CodeW-1:0];
        CfgInvertLevel: invert_q       <= cfg_data_i[0];
      endcase
    end
  end

  // input register
  logic            s1_valid_q;
  logic [DurW-1:0] s1_dur_q;
  logic            s1_level_q;
  logic            out_free;
  logic            fire;
  logic            in_acc;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_dur_q   <= pulse_duration_i;
      s1_level_q <= line_level_i;
    end
  end

  // decode state
  logic [CountW-1:0]      pre_cnt_q, pre_cnt_d;
  logic                   hdr_seen_q, hdr_seen_d;
  logic [CodeW-1:0]       bit_cnt_q, bit_cnt_d;
  logic [MaxCodeBits-1:0] bits_q, bits_d;
  logic [SerialW-1:0]     ser_q, ser_d;
  logic [CryptW-1:0]      enc_q, enc_d;
  logic [ButtonW+1:0]     flags_q, flags_d;
  logic                   emit;

  // pulse classification
  logic [Tol4W-1:0] tol4;
  logic             gap;
  logic             long_pause;
  logic             te_win;
  logic             hdr_win;
  logic             tail_win;
  logic             data_win;
  logic             data_bit;

  assign tol4       = {tol_q, 2'b00};
  assign gap        = (s1_level_q == invert_q);
  assign long_pause = s1_dur_q > max_pause_q;
  assign te_win     = in_win(s1_dur_q, DurW'(unit_time_q), Tol4W'(tol_q));
  assign hdr_win    = in_win(s1_dur_q, hdr_c_q, tol4);
  assign tail_win   = in_win(s1_dur_q, tail_c_q, tol4);
  assign data_win   = ((WinW'(s1_dur_q) + WinW'(tol_q)) > WinW'(unit_time_q)) &&
                      (WinW'(s1_dur_q) < (WinW'({unit_time_q, 1'b0}) + WinW'(tol_q)));
  // short pulse (up to 1.5 unit times) is a one
  assign data_bit   = !(WinW'({s1_dur_q, 1'b0}) > (WinW'(unit_time_q) * WinW'(2'd3)));

  // next decode state for the held item
  always_comb begin
    logic [CountW-1:0]      pc;
    logic                   done;
    logic                   store;
    logic [MaxCodeBits-1:0] nb;
    pc         = pre_cnt_q;
    done       = 1'b0;
    store      = 1'b0;
    nb         = bits_q;
    pre_cnt_d  = pre_cnt_q;
    hdr_seen_d = hdr_seen_q;
    bit_cnt_d  = bit_cnt_q;
    bits_d     = bits_q;
    ser_d      = ser_q;
    enc_d      = enc_q;
    flags_d    = flags_q;
    emit       = 1'b0;

    if (long_pause) begin
      pre_cnt_d  = '0;
      hdr_seen_d = 1'b0;
      done       = 1'b1;
    end else if ((pre_cnt_q < preamble_len_q) && te_win) begin
      pre_cnt_d  = pre_cnt_q + CountW'(1);
      hdr_seen_d = 1'b0;
      done       = 1'b1;
    end else if (pre_cnt_q < preamble_len_q) begin
      pc        = '0;
      pre_cnt_d = '0;
    end

    if (!done) begin
      if (gap && (pc == preamble_len_q) && !hdr_seen_q) begin
        // header pulse
        if (hdr_win) begin
          hdr_seen_d = 1'b1;
          bit_cnt_d  = '0;
        end else begin
          pre_cnt_d  = '0;
          hdr_seen_d = 1'b0;
        end
      end else if (!gap && (pc == preamble_len_q) && hdr_seen_q) begin
        // data pulse
        if (!data_win) begin
          pre_cnt_d = '0;
        end else if ((bit_cnt_q < code_len_q) &&
                     (bit_cnt_q < CodeW'(MaxCodeBits))) begin
          store     = 1'b1;
          bit_cnt_d = bit_cnt_q + CodeW'(1);
        end
      end else if (gap && (tail_len_q != '0) && (bit_cnt_q == code_len_q)) begin
        // tail pulse repeats the stored fields
        emit = tail_win;
      end
    end

    // bit store with the new bit in place
    for (int k = 0; k < MaxCodeBits; k++) begin
      if (store && (bit_cnt_q[BitIdxW-1:0] == BitIdxW'(k))) begin
        nb[k] = data_bit;
      end
    end
    bits_d = nb;

    // frame completion and field split
    if (store && (bit_cnt_d == code_len_q)) begin
      if (code_len_q == CodeW'(LongFrame)) begin
        ser_d     = nb[LongSerLsb +: SerialW];
        enc_d     = nb[CryptW-1:0];
        flags_d   = {nb[65], nb[64], nb[60], nb[63], nb[62], nb[61]};
        pre_cnt_d = '0;
      end else if (code_len_q == CodeW'(ShortFrame)) begin
        ser_d = '0;
        for (int j = 0; j < ShortSerW; j++) begin
          ser_d[ShortSerW-1-j] = nb[j];
        end
        enc_d   = '0;
        flags_d = '0;
      end
      emit = (tail_len_q == '0);
    end
  end

  // decode state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q  <= '0;
      hdr_seen_q <= 1'b0;
      bit_cnt_q  <= '0;
      ser_q      <= '0;
      enc_q      <= '0;
      flags_q    <= '0;
    end else if (fire) begin
      pre_cnt_q  <= pre_cnt_d;
      hdr_seen_q <= hdr_seen_d;
      bit_cnt_q  <= bit_cnt_d;
      ser_q      <= ser_d;
      enc_q      <= enc_d;
      flags_q    <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      bits_q <= bits_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fire && emit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      serial_number_o  <= ser_d;
      encrypted_word_o <= enc_d;
      button_bits_o    <= flags_d[ButtonW-1:0];
      battery_low_o    <= flags_d[ButtonW];
      repeat_flag_o    <= flags_d[ButtonW+1];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpwd_checker.sv =====
// ----------------------------------------------------------------------------
// rpwd_checker
// Port-level checks of the pulse-width remote decoder, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwd_checker
  import rpwd_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [SerialW-1:0] serial_number_o,
  input wire logic [CryptW-1:0]  encrypted_word_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(serial_number_o) && $stable(encrypted_word_o))
    else $error("result fields changed while stalled");

  // input backpressure only comes from a full, stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // a fresh result follows an accepted item, via the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching item");

endmodule

bind remote_pulse_width_decoder_top rpwd_checker u_rpwd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .serial_number_o  (serial_number_o),
  .encrypted_word_o (encrypted_word_o)
);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the pulse-width remote decoder. Edge items go in
// through the valid/stall channel: first a table of hand-picked edges at
// the register defaults, then phases of well-formed frames with random
// content, mixed with noise, pauses and broken pulses. Each phase loads new
// register settings through the write channel. A local model of the
// decoder predicts every frame report, which is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import rpwd_pkg::*;

  localparam int unsigned ItemTarget = 1950;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DirRows    = 23;

  // one decoded frame report
  typedef struct packed {
    logic [SerialW-1:0] serial;
    logic [CryptW-1:0]  crypt;
    logic [ButtonW-1:0] buttons;
    logic               batt;
    logic               rpt;
  } frame_t;

  // register settings as the decoder holds them
  typedef struct packed {
    logic [TimeW-1:0]  unit_time;
    logic [TimeW-1:0]  tol;
    logic [DurW-1:0]   max_pause;
    logic [CountW-1:0] preamble;
    logic [CountW-1:0] header;
    logic [CountW-1:0] tail;
    logic [CodeW-1:0]  code_len;
    logic              invert;
  } cfg_t;

  // directed edge, with a hand-read outcome where typed is set
  typedef struct packed {
    logic [DurW-1:0]    dur;
    logic               lvl;
    logic               typed;
    logic               hit;
    logic [SerialW-1:0] serial;
  } row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [DurW-1:0] pulse_duration_i = '0;
  logic line_level_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [SerialW-1:0] serial_number_o;
  logic [CryptW-1:0] encrypted_word_o;
  logic [ButtonW-1:0] button_bits_o;
  logic battery_low_o;
  logic repeat_flag_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // decoder model state
  cfg_t               dec_cfg;
  logic [CountW-1:0]  pre_cnt = '0;
  logic               hdr_seen = 1'b0;
  logic [CodeW-1:0]   bit_cnt = '0;
  logic               bit_mem [MaxCodeBits];
  logic [SerialW-1:0] ser_q = '0;
  logic [CryptW-1:0]  enc_q = '0;
  logic [5:0]         flag_q = '0;

  frame_t pending_frames [$];
  int unsigned errors = 0;
  int unsigned edges_sent = 0;
  int unsigned frames_seen = 0;
  int unsigned settings_used = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // hand-picked edges at the register defaults: te 320, tol 100, header 36
  row_t dir_rows [DirRows] = '{
    '{24'hFFFFFF, 1'b1, 1'b1, 1'b0, 28'h0},   // longest pause
    '{24'd0,      1'b0, 1'b1, 1'b0, 28'h0},   // zero length, bad header
    '{24'd11121,  1'b0, 1'b1, 1'b0, 28'h0},   // header at lower edge
    '{24'd221,    1'b1, 1'b0, 1'b0, 28'h0},   // shortest one
    '{24'd739,    1'b1, 1'b0, 1'b0, 28'h0},   // longest zero
    '{24'd480,    1'b1, 1'b0, 1'b0, 28'h0},   // one at split point
    '{24'd481,    1'b1, 1'b0, 1'b0, 28'h0},   // zero just past split
    '{24'd640,    1'b1, 1'b0, 1'b0, 28'h0},
    '{24'd320,    1'b1, 1'b0, 1'b0, 28'h0},
    '{24'd640,    1'b1, 1'b0, 1'b0, 28'h0},
    '{24'd320,    1'b1, 1'b0, 1'b0, 28'h0},
    '{24'd320,    1'b1, 1'b0, 1'b0, 28'h0},
    '{24'd320,    1'b1, 1'b0, 1'b0, 28'h0},
    '{24'd320,    1'b1, 1'b0, 1'b0, 28'h0},
    '{24'd320,    1'b1, 1'b1, 1'b1, 28'hA5F}, // last bit, 12-bit serial
    '{24'd320,    1'b1, 1'b1, 1'b0, 28'h0},   // frame done, bit not kept
    '{24'd11919,  1'b0, 1'b0, 1'b0, 28'h0},
    '{24'd20000,  1'b1, 1'b0, 1'b0, 28'h0},   // pause equal to limit
    '{24'd20001,  1'b0, 1'b1, 1'b0, 28'h0},   // pause just over limit
    '{24'd11920,  1'b0, 1'b1, 1'b0, 28'h0},   // header at upper edge, outside
    '{24'd11520,  1'b0, 1'b0, 1'b0, 28'h0},
    '{24'd740,    1'b1, 1'b0, 1'b0, 28'h0},   // data just too long
    '{24'd220,    1'b1, 1'b0, 1'b0, 28'h0}    // data just too short
  };

  remote_pulse_width_decoder_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pulse_duration_i (pulse_duration_i),
    .line_level_i     (line_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .serial_number_o  (serial_number_o),
    .encrypted_word_o (encrypted_word_o),
    .button_bits_o    (button_bits_o),
    .battery_low_o    (battery_low_o),
    .repeat_flag_o    (repeat_flag_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // open window test, exact signed arithmetic
  function automatic bit in_window(input longint d, input longint c, input longint t);
    return (d > c - t) && (d < c + t);
  endfunction

  function automatic frame_t stored_frame();
    frame_t f;
    f.serial  = ser_q;
    f.crypt   = enc_q;
    f.buttons = flag_q[3:0];
    f.batt    = flag_q[4];
    f.rpt     = flag_q[5];
    return f;
  endfunction

  // decoder model: one edge in, at most one frame report out
  function automatic bit decode_edge(input logic [DurW-1:0] dur, input logic lvl,
                                     output frame_t res);
    longint d, te, tol, hl, tl;
    logic gap;
    logic [SerialW-1:0] v;
    int j;
    res = '0;
    d   = dur;
    te  = dec_cfg.unit_time;
    tol = dec_cfg.tol;
    hl  = dec_cfg.header;
    tl  = dec_cfg.tail;
    gap = (lvl == dec_cfg.invert);
    v   = '0;
    // long pause restarts the search
    if (dur > dec_cfg.max_pause) begin
      pre_cnt  = '0;
      hdr_seen = 1'b0;
      return 1'b0;
    end
    // preamble pulses
    if (pre_cnt < dec_cfg.preamble) begin
      if (in_window(d, te, tol)) begin
        pre_cnt  = pre_cnt + 1'b1;
        hdr_seen = 1'b0;
        return 1'b0;
      end
      pre_cnt = '0;
    end
    // header pulse on the gap level
    if (gap && pre_cnt == dec_cfg.preamble && !hdr_seen) begin
      if (in_window(d, te * hl, tol * 4)) begin
        hdr_seen = 1'b1;
        bit_cnt  = '0;
      end else begin
        pre_cnt  = '0;
        hdr_seen = 1'b0;
      end
      return 1'b0;
    end
    // data bits on the other level
    if (!gap && pre_cnt == dec_cfg.preamble && hdr_seen) begin
      if (d > te - tol && d < te * 2 + tol) begin
        if (bit_cnt < dec_cfg.code_len && bit_cnt < MaxCodeBits) begin
          bit_mem[bit_cnt] = (d > te * 3 / 2) ? 1'b0 : 1'b1;
          bit_cnt = bit_cnt + 1'b1;
          if (bit_cnt == dec_cfg.code_len) begin
            // split the finished frame into fields
            if (dec_cfg.code_len == CodeW'(LongFrame)) begin
              for (j = 0; j < 28; j++) v[j] = bit_mem[LongSerLsb + j];
              ser_q = v;
              for (j = 0; j < 32; j++) enc_q[j] = bit_mem[j];
              flag_q  = {bit_mem[65], bit_mem[64], bit_mem[60],
                         bit_mem[63], bit_mem[62], bit_mem[61]};
              pre_cnt = '0;
            end else if (dec_cfg.code_len == CodeW'(ShortFrame)) begin
              for (j = 0; j < 12; j++) v = {v[SerialW-2:0], bit_mem[j]};
              ser_q  = v;
              enc_q  = '0;
              flag_q = '0;
            end
            if (tl != 0) return 1'b0;
            res = stored_frame();
            return 1'b1;
          end
        end
      end else begin
        pre_cnt = '0;
      end
    end
    // tail pulse, repeated reports while the frame stays done
    if (gap && tl > 0 && bit_cnt == dec_cfg.code_len) begin
      if (in_window(d, te * tl, tol * 4)) begin
        res = stored_frame();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // random duration strictly in (lo, hi) if possible, never over max_pause
  function automatic logic [DurW-1:0] pick_dur(input longint lo, input longint hi);
    longint a, b, mp;
    mp = dec_cfg.max_pause;
    a  = (lo + 1 < 0) ? 0 : lo + 1;
    b  = (hi - 1 > mp) ? mp : hi - 1;
    if (a > b) return DurW'($urandom_range(32'(mp)));
    return DurW'($urandom_range(32'(b), 32'(a)));
  endfunction

  // offer one edge item, predict its outcome once it is taken
  task automatic send_edge(input logic [DurW-1:0] dur, input logic lvl, input logic typed,
                           input logic typed_hit, input logic [SerialW-1:0] typed_serial);
    frame_t res;
    bit hit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    pulse_duration_i <= dur;
    line_level_i     <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    edges_sent++;
    hit = decode_edge(dur, lvl, res);
    if (typed) begin
      hit        = typed_hit;
      res        = '0;
      res.serial = typed_serial;
    end
    if (hit) pending_frames.push_back(res);
  endtask

  // edge of a frame, now and then replaced by a broken one
  task automatic send_pulse(input logic [DurW-1:0] dur, input logic lvl);
    if ($urandom_range(99) < 3)
      send_edge(DurW'($urandom()), 1'($urandom_range(1)), 1'b0, 1'b0, '0);
    else
      send_edge(dur, lvl, 1'b0, 1'b0, '0);
  endtask

  // well-formed frame under the current settings, random bits
  task automatic send_frame();
    longint te, tol, hl, tl, half;
    int n, i;
    logic gap;
    te   = dec_cfg.unit_time;
    tol  = dec_cfg.tol;
    hl   = dec_cfg.header;
    tl   = dec_cfg.tail;
    half = te * 3 / 2;
    gap  = dec_cfg.invert;
    if ($urandom_range(9) < 7 && dec_cfg.max_pause != {DurW{1'b1}})
      send_pulse(DurW'($urandom_range(32'hFFFFFF, 32'(dec_cfg.max_pause) + 1)),
                 1'($urandom_range(1)));
    repeat (dec_cfg.preamble) send_pulse(pick_dur(te - tol, te + tol), 1'($urandom_range(1)));
    send_pulse(pick_dur(te * hl - tol * 4, te * hl + tol * 4), gap);
    if (dec_cfg.code_len == 0) n = 0;
    else if (dec_cfg.code_len > MaxCodeBits) n = MaxCodeBits + 4;
    else n = dec_cfg.code_len;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(1)) send_pulse(pick_dur(te - tol, half + 1), ~gap);
      else send_pulse(pick_dur(half, te * 2 + tol), ~gap);
      if (i != n - 1) send_pulse(pick_dur(-1, longint'(dec_cfg.max_pause) + 1), gap);
    end
    if (tl != 0)
      repeat ($urandom_range(3, 1)) send_pulse(pick_dur(te * tl - tol * 4, te * tl + tol * 4), gap);
  endtask

  // write one register, valid stays high for the next write
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgUnitTime:    dec_cfg.unit_time = val[TimeW-1:0];
      CfgTolerance:   dec_cfg.tol       = val[TimeW-1:0];
      CfgMaxPause:    dec_cfg.max_pause = val[DurW-1:0];
      CfgPreamble:    dec_cfg.preamble  = val[CountW-1:0];
      CfgHeader:      dec_cfg.header    = val[CountW-1:0];
      CfgTail:        dec_cfg.tail      = val[CountW-1:0];
      CfgCodeLength:  dec_cfg.code_len  = val[CodeW-1:0];
      CfgInvertLevel: dec_cfg.invert    = val[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(CfgUnitTime, CfgDataW'(c.unit_time));
    write_reg(CfgTolerance, CfgDataW'(c.tol));
    write_reg(CfgMaxPause, CfgDataW'(c.max_pause));
    write_reg(CfgPreamble, CfgDataW'(c.preamble));
    write_reg(CfgHeader, CfgDataW'(c.header));
    write_reg(CfgTail, CfgDataW'(c.tail));
    write_reg(CfgCodeLength, CfgDataW'(c.code_len));
    write_reg(CfgInvertLevel, CfgDataW'(c.invert));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // stop sending until every report is out, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // report checker
  always @(posedge clk_i) begin : check_out
    frame_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_frames.size() == 0) begin
        errors++;
        $display("%0t: report with nothing pending, serial %h", $time, serial_number_o);
      end else begin
        want = pending_frames.pop_front();
        frames_seen++;
        if (serial_number_o !== want.serial) begin
          errors++;
          $display("%0t: serial expected %h got %h", $time, want.serial, serial_number_o);
        end
        if (encrypted_word_o !== want.crypt) begin
          errors++;
          $display("%0t: hopping word expected %h got %h", $time, want.crypt,
                   encrypted_word_o);
        end
        if (button_bits_o !== want.buttons) begin
          errors++;
          $display("%0t: buttons expected %h got %h", $time, want.buttons, button_bits_o);
        end
        if (battery_low_o !== want.batt) begin
          errors++;
          $display("%0t: battery expected %b got %b", $time, want.batt, battery_low_o);
        end
        if (repeat_flag_o !== want.rpt) begin
          errors++;
          $display("%0t: repeat expected %b got %b", $time, want.rpt, repeat_flag_o);
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    cfg_t next_cfg;
    int unsigned phase, budget, start, mode;
    int unsigned te_r, tol_r, hl_r, tl_r, longest, r;
    int i;
    dec_cfg = '{UnitTimeRst, TolRst, MaxPauseRst, PreambleRst, HeaderRst, TailRst,
                CodeLenRst, 1'b0};
    for (i = 0; i < MaxCodeBits; i++) bit_mem[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed edges at the defaults
    for (i = 0; i < DirRows; i++)
      send_edge(dir_rows[i].dur, dir_rows[i].lvl, dir_rows[i].typed, dir_rows[i].hit,
                dir_rows[i].serial);

    // phases of frames and noise, new settings each time
    phase = 0;
    while (edges_sent < ItemTarget + DirRows) begin
      drain();
      case (phase)
        0: next_cfg = '{16'd320, 16'd100, 24'd20000, 8'd4, 8'd12, 8'd0, 7'd66, 1'b0};
        1: next_cfg = '{16'd400, 16'd120, 24'd30000, 8'd0, 8'd20, 8'd3, 7'd12, 1'b1};
        2: next_cfg = '{16'd250, 16'd80, 24'd15000, 8'd2, 8'd30, 8'd2, 7'd5, 1'b0};
        3: next_cfg = '{16'd300, 16'd90, 24'd15000, 8'd0, 8'd10, 8'd4, 7'd0, 1'b1};
        4: next_cfg = '{16'd300, 16'd90, 24'd15000, 8'd1, 8'd10, 8'd0, 7'd100, 1'b0};
        5: next_cfg = '{16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 7'd66, 1'b1};
        6: next_cfg = '{16'd0, 16'd0, 24'd0, 8'd0, 8'd0, 8'd0, 7'd1, 1'b0};
        default: begin
          te_r  = $urandom_range(600, 150);
          tol_r = $urandom_range(te_r / 3, 20);
          hl_r  = $urandom_range(40, 4);
          tl_r  = $urandom_range(1) ? 0 : $urandom_range(12, 1);
          longest = te_r * ((hl_r > tl_r) ? hl_r : tl_r) + 4 * tol_r;
          next_cfg.unit_time = TimeW'(te_r);
          next_cfg.tol       = TimeW'(tol_r);
          next_cfg.max_pause = ($urandom_range(9) < 2) ? {DurW{1'b1}} :
                               DurW'(longest + $urandom_range(6000));
          next_cfg.preamble  = CountW'($urandom_range(6));
          next_cfg.header    = CountW'(hl_r);
          next_cfg.tail      = CountW'(tl_r);
          r = $urandom_range(19);
          if (r < 6) next_cfg.code_len = CodeW'(ShortFrame);
          else if (r < 10) next_cfg.code_len = CodeW'(LongFrame);
          else if (r < 19) next_cfg.code_len = CodeW'($urandom_range(24, 1));
          else next_cfg.code_len = CodeW'($urandom_range(127, 67));
          next_cfg.invert    = 1'($urandom_range(1));
        end
      endcase
      load_settings(next_cfg);

      // idle pattern of this phase
      mode = phase % 4;
      send_idle_pct  = (mode == 1) ? 78 : (mode == 3) ? 20 : 0;
      recv_stall_pct = (mode == 2) ? 78 : (mode == 3) ? 20 : 0;

      budget = (phase == 5 || phase == 6) ? 60 : 130;
      start  = edges_sent;
      while (edges_sent - start < budget) begin
        if ($urandom_range(9) < 8) send_frame();
        repeat ($urandom_range(3)) begin
          if ($urandom_range(1))
            send_edge(DurW'($urandom()), 1'($urandom_range(1)), 1'b0, 1'b0, '0);
          else
            send_edge(DurW'($urandom_range(3 * dec_cfg.unit_time + 4 * dec_cfg.tol)),
                      1'($urandom_range(1)), 1'b0, 1'b0, '0);
        end
      end
      phase++;
    end
    drain();

    $display("covered %0d edge items and %0d frame reports over %0d register settings",
             edges_sent, frames_seen, settings_used);
    $display("phases ran without idling, with sender gaps, receiver stalls and both");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/rpwd_pkg.sv
rtl/core/remote_pulse_width_decoder_top.sv
rtl/core/rpwd_checker.sv
bench/tb.sv
